### design/drs_pkg.sv
// Package for dense_rank_of_scores: FSM state type, cell control word and
// fixed port widths. No dependencies.
`default_nettype none
package drs_pkg;

  localparam int SCORE_IN_W = 16;
  localparam int RANK_W     = 7;
  localparam int POS_W      = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INIT,
    ST_ROT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic write;
    logic init;
    logic rotate;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

### design/drs_cell.sv
// One cell of the rank chain: holds a score, its first-occurrence flag, a
// circulating token and a rank counter. Depends on drs_pkg.
`default_nettype none
module drs_cell #(
  parameter int SCORE_BITS = 16,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                          clk,
  input  drs_pkg::cell_ctl_t            ctl,
  input  logic signed [SCORE_BITS-1:0]  new_score,
  input  logic                          new_uniq,
  input  logic        [CNT_W-1:0]       count,
  input  logic signed [SCORE_BITS-1:0]  trav_in,
  input  logic                          ok_in,
  input  logic        [CNT_W-1:0]       cnt_in,
  output logic signed [SCORE_BITS-1:0]  trav_out,
  output logic                          ok_out,
  output logic        [CNT_W-1:0]       cnt_out,
  output logic                          match
);

  logic signed [SCORE_BITS-1:0] score;
  logic                         uniq;
  logic signed [SCORE_BITS-1:0] trav;
  logic                         trav_ok;
  logic        [CNT_W-1:0]      cnt;
  logic                         valid;

  assign valid    = CNT_W'(INDEX) < count;
  assign match    = valid && (score == new_score);
  assign trav_out = trav;
  assign ok_out   = trav_ok;
  assign cnt_out  = cnt;

  always_ff @(posedge clk) begin
    if (ctl.write && (count == CNT_W'(INDEX))) begin
      score <= new_score;
      uniq  <= new_uniq;
    end
  end

  // token pass: count distinct higher scores as they go by
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      trav    <= score;
      trav_ok <= uniq && valid;
      cnt     <= CNT_W'(1);
    end else if (ctl.rotate) begin
      if (trav_ok && (trav > score)) begin
        cnt <= cnt + CNT_W'(1);
      end
      trav    <= trav_in;
      trav_ok <= ok_in;
    end else if (ctl.shift) begin
      cnt <= cnt_in;
    end
  end

endmodule
`default_nettype wire

### design/drs_ctrl.sv
// Sequencer for dense_rank_of_scores: item count, phase FSM, rotation and
// output counters, handshakes. Depends on drs_pkg.
`default_nettype none
module drs_ctrl #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                last,
  input  logic                                out_ready,
  output logic                                in_ready,
  output logic                                out_valid,
  output logic                                final_res,
  output logic [drs_pkg::POS_W-1:0]           position,
  output logic [$clog2(MAX_ITEMS+1)-1:0]      count,
  output drs_pkg::cell_ctl_t                  ctl
);
  import drs_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);

  state_t           state, state_next;
  logic [IDX_W-1:0] rot;
  logic [IDX_W-1:0] pos;
  logic             full;
  logic             in_acc;
  logic             out_acc;
  logic             rot_done;

  assign full      = count == CNT_W'(MAX_ITEMS);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign rot_done  = rot == IDX_W'(MAX_ITEMS - 1);
  assign final_res = (CNT_W'(pos) + CNT_W'(1)) == count;
  assign position  = POS_W'(pos);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_valid && last) state_next = ST_INIT;
      ST_INIT: state_next = ST_ROT;
      ST_ROT:  if (rot_done) state_next = ST_OUT;
      ST_OUT:  if (out_ready && final_res) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctl.init   = 1'b0;
    ctl.rotate = 1'b0;
    unique case (state)
      ST_LOAD: in_ready   = 1'b1;
      ST_INIT: ctl.init   = 1'b1;
      ST_ROT:  ctl.rotate = 1'b1;
      ST_OUT:  out_valid  = 1'b1;
      default: ;
    endcase
    ctl.write = in_acc && !full;
    ctl.shift = out_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      if (out_acc && final_res) begin
        count <= '0;
      end else if (ctl.write) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      rot <= '0;
      pos <= '0;
    end else begin
      if (ctl.rotate) rot <= rot + IDX_W'(1);
      if (out_acc)    pos <= pos + IDX_W'(1);
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output phases overlap");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("item count above capacity");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    (out_acc && final_res) |=> (count == '0) && in_ready)
    else $error("set not cleared after final rank");

  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0))
    else $error("rank output with empty set");

endmodule
`default_nettype wire

### design/dense_rank_of_scores.sv
// Top level of dense_rank_of_scores: chain of drs_cell plus drs_ctrl.
// Depends on drs_pkg, drs_cell, drs_ctrl.
//
//   channel | handshake           | words
//   in      | in_valid / in_ready | score, last
//   out     | out_valid/out_ready | rank, position, final_res
//
// Loading keeps in_ready high; each word is checked for duplicates against all loaded cells.
// After the last word: a setup state, then token rotation around the cell
// ring, then one rank per cycle while out_ready is high.
// A set of n scores gives n rank words.
// Reset clears the count and sequencer; cell contents are not reset.
// Output stalls hold the chain; no input is taken until the set is drained.
`default_nettype none
module dense_rank_of_scores #(
  parameter int MAX_ITEMS  = 64,
  parameter int SCORE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [drs_pkg::SCORE_IN_W-1:0] score,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [drs_pkg::RANK_W-1:0]     rank,
  output logic        [drs_pkg::POS_W-1:0]      position,
  output logic                                  final_res
);
  import drs_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  cell_ctl_t                    ctl;
  logic        [CNT_W-1:0]      count;
  logic signed [SCORE_BITS-1:0] s_in;
  logic        [MAX_ITEMS-1:0]  match;
  logic signed [SCORE_BITS-1:0] trav [MAX_ITEMS];
  logic                         ok   [MAX_ITEMS];
  logic        [CNT_W-1:0]      cnt  [MAX_ITEMS];
  logic                         new_uniq;

  assign s_in     = SCORE_BITS'(score);
  assign new_uniq = !(|match);
  assign rank     = RANK_W'(cnt[0]);

  drs_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .out_ready(out_ready),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .final_res(final_res),
    .position (position),
    .count    (count),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    drs_cell #(
      .SCORE_BITS(SCORE_BITS),
      .CNT_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_score(s_in),
      .new_uniq (new_uniq),
      .count    (count),
      .trav_in  (trav[(i + 1) % MAX_ITEMS]),
      .ok_in    (ok[(i + 1) % MAX_ITEMS]),
      .cnt_in   (cnt[(i + 1) % MAX_ITEMS]),
      .trav_out (trav[i]),
      .ok_out   (ok[i]),
      .cnt_out  (cnt[i]),
      .match    (match[i])
    );
  end

endmodule
`default_nettype wire

### bench/rank_checker.sv
// Checker for dense_rank_of_scores: watches both channels, predicts each
// rank word from the scores taken in, and compares. Depends on drs_pkg.
`timescale 1ns / 1ps
module rank_checker #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [drs_pkg::SCORE_IN_W-1:0] score,
  input  logic                                  last,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic        [drs_pkg::RANK_W-1:0]     rank,
  input  logic        [drs_pkg::POS_W-1:0]      position,
  input  logic                                  final_res,
  output int                                    errors,
  output int                                    pending
);
  import drs_pkg::*;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [POS_W-1:0]  pos;
    logic              fin;
  } rank_word_t;

  logic signed [SCORE_IN_W-1:0] held [MAX_ITEMS];
  int                           held_n;
  rank_word_t                   ranks_due [$];

  // distinct scores above held[idx], plus one
  function automatic int dense_rank(int idx);
    int higher;
    bit fresh;
    higher = 0;
    for (int j = 0; j < held_n; j++) begin
      if (held[j] > held[idx]) begin
        fresh = 1'b1;
        for (int k = 0; k < j; k++) begin
          if (held[k] == held[j]) fresh = 1'b0;
        end
        if (fresh) higher++;
      end
    end
    return higher + 1;
  endfunction

  always @(posedge clk) begin
    rank_word_t want;
    if (rst) begin
      held_n = 0;
      ranks_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (ranks_due.size() == 0) begin
          errors++;
          $error("unexpected word: rank %0d position %0d final_res %0b",
                 rank, position, final_res);
        end else begin
          want = ranks_due.pop_front();
          if (rank !== want.rank) begin
            errors++;
            $error("rank: expected %0d, got %0d", want.rank, rank);
          end
          if (position !== want.pos) begin
            errors++;
            $error("position: expected %0d, got %0d", want.pos, position);
          end
          if (final_res !== want.fin) begin
            errors++;
            $error("final_res: expected %0b, got %0b", want.fin, final_res);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (held_n < MAX_ITEMS) begin
          held[held_n] = score;
          held_n++;
        end
        if (last) begin
          for (int i = 0; i < held_n; i++) begin
            want.rank = RANK_W'(dense_rank(i));
            want.pos  = POS_W'(i);
            want.fin  = (i == held_n - 1);
            ranks_due.push_back(want);
          end
          held_n = 0;
        end
      end
    end
    pending = ranks_due.size();
  end

endmodule

### bench/tb_dense_rank_of_scores.sv
// Top of the dense_rank_of_scores testbench: clock, reset, score stimulus
// and rank word acceptance; checking is done in rank_checker.
// Depends on drs_pkg, dense_rank_of_scores and rank_checker.
`timescale 1ns / 1ps
module tb_dense_rank_of_scores;
  import drs_pkg::*;

  localparam int MAX_ITEMS = 64;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic signed [SCORE_IN_W-1:0] score     = '0;
  logic                         last      = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic        [RANK_W-1:0]     rank;
  logic        [POS_W-1:0]      position;
  logic                         final_res;

  int       errs;
  int       pending;
  int       snd_idle  = 0;
  int       rcv_idle  = 0;
  logic [1:0] phase   = 2'd0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       words_sent, sets_sent, full_sets;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dense_rank_of_scores #(.MAX_ITEMS(MAX_ITEMS), .SCORE_BITS(16)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .score(score), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .rank(rank), .position(position), .final_res(final_res)
  );

  rank_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .score(score), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .rank(rank), .position(position), .final_res(final_res),
    .errors(errs), .pending(pending)
  );

  // receiver; long hold-off when the no-idle phase begins
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (phase == 2'd3 && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_word(input logic [SCORE_IN_W-1:0] s, input logic l);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    score    <= s;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (l) sets_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [SCORE_IN_W-1:0] pick_score();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return SCORE_IN_W'($urandom_range(6) - 3);
    if (sel < 60) begin
      case ($urandom_range(3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return SCORE_IN_W'($urandom());
  endfunction

  task automatic run_sets(input int budget);
    int sent, sz, sel;
    sent = 0;
    while (sent < budget) begin
      sel = $urandom_range(99);
      if (sel < 75)      sz = $urandom_range(8, 1);
      else if (sel < 88) sz = $urandom_range(40, 9);
      else if (sel < 94) sz = MAX_ITEMS;
      else               sz = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS + 1);
      if (sz >= MAX_ITEMS) full_sets++;
      for (int i = 0; i < sz; i++) send_word(pick_score(), i == sz - 1);
      sent += sz;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single score, extremes with ties, all equal, alternating bits, pair
    send_word(16'h8000, 1'b1);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b1);
    send_word(16'd5, 1'b0);
    send_word(16'd5, 1'b0);
    send_word(16'd5, 1'b1);
    send_word(16'h5555, 1'b0);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFE, 1'b1);
    send_word(16'd100, 1'b0);
    send_word(-16'sd100, 1'b1);
    drain();

    snd_idle = 30;
    rcv_idle <= 57;
    phase    <= 2'd1;
    run_sets(135);
    drain();

    snd_idle = 57;
    rcv_idle <= 30;
    phase    <= 2'd2;
    run_sets(135);
    drain();

    snd_idle = 0;
    rcv_idle <= 0;
    phase    <= 2'd3;
    run_sets(135);
    drain();

    repeat (200) @(posedge clk);
    $display("Sent %0d score words in %0d sets (%0d at or past capacity),",
             words_sent, sets_sent, full_sets);
    $display("under sender/receiver idling mixes 30/57, 57/30 and none.");
    if (errs == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
